// ===== rtl/sdx_pkg.sv =====
package sdx_pkg;

	localparam int CODE_LENGTH_DEF = 4;
	localparam int OUT_CHARS = 4;

	localparam logic [7:0] PAD_CHAR = 8'h30;
	localparam logic [7:0] DIGIT_1 = 8'h31;
	localparam logic [7:0] DIGIT_2 = 8'h32;
	localparam logic [7:0] DIGIT_3 = 8'h33;
	localparam logic [7:0] DIGIT_4 = 8'h34;
	localparam logic [7:0] DIGIT_5 = 8'h35;
	localparam logic [7:0] DIGIT_6 = 8'h36;

	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic [7:0] char_in;
		logic       word_end;
		logic       empty_word;
	} sdx_word_t;

	typedef struct packed {
		logic [7:0] code_char0;
		logic [7:0] code_char1;
		logic [7:0] code_char2;
		logic [7:0] code_char3;
		logic [2:0] code_length;
	} sdx_code_t;

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		if (c >= LOWER_A && c <= LOWER_Z) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic logic [7:0] letter_code(input logic [7:0] c);
		logic [7:0] d;
		unique case (c)
			" ", "A", "E", "H", "I", "O", "U", "W", "Y": d = PAD_CHAR;
			"B", "F", "P", "V": d = DIGIT_1;
			"C", "G", "J", "K", "Q", "S", "X", "Z": d = DIGIT_2;
			"D", "T": d = DIGIT_3;
			"L": d = DIGIT_4;
			"M", "N": d = DIGIT_5;
			"R": d = DIGIT_6;
			default: d = c;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/sdx_word_if.sv =====
interface sdx_word_if import sdx_pkg::*; ();
	logic      valid;
	logic      ready;
	sdx_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/sdx_code_if.sv =====
interface sdx_code_if import sdx_pkg::*; ();
	logic      valid;
	logic      ready;
	sdx_code_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/soundex_word_encoder_core.sv =====
// Soundex encoder that takes a word one character per cycle and returns its
// code, up to four characters, on the word's last character, or a zero-length
// code for an empty word. A new character is accepted in every cycle while the
// output side keeps taking codes; a code passes through the input register and
// then the result register. The code of a word in progress is held in the
// accumulator, which updates as each character leaves the input register.
module soundex_word_encoder_core import sdx_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sdx_word_if.sink   word_in,
	sdx_code_if.source code_out
);

	logic      item_valid_s1;
	sdx_word_t item_s1;
	logic      advance;
	logic      has_result;
	sdx_code_t result;
	logic      out_free;
	logic      load;

	assign advance = item_valid_s1 && (!has_result || out_free);
	assign load = advance && has_result;

	sdx_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_in       (word_in),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	sdx_code_acc #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_code_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.has_result (has_result),
		.result     (result)
	);

	sdx_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.result   (result),
		.free     (out_free),
		.code_out (code_out)
	);

`ifndef SYNTHESIS
	a_empty_gives_zero_length: assert property (@(posedge clk) disable iff (!arst_n)
		(load && item_s1.empty_word) |=> (code_out.valid && code_out.data.code_length == 3'd0))
		else $error("empty word did not give a zero-length code");

	a_word_gives_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !item_s1.empty_word) |=> (code_out.valid && code_out.data.code_length != 3'd0))
		else $error("finished word gave a zero-length code");

	a_stalled_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && !advance) |=> (item_valid_s1 && $stable(item_s1)))
		else $error("stalled word lost from the input register");
`endif

endmodule

// ===== rtl/sdx_in_stage.sv =====
module sdx_in_stage import sdx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sdx_word_if.sink  word_in,
	input  logic      advance,
	output logic      item_valid_s1,
	output sdx_word_t item_s1
);

	assign word_in.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (word_in.ready) begin
			item_valid_s1 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_in.ready && word_in.valid) begin
			item_s1 <= word_in.data;
		end
	end

endmodule

// ===== rtl/sdx_code_acc.sv =====
module sdx_code_acc import sdx_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  sdx_word_t item,
	output logic      has_result,
	output sdx_code_t result
);

	localparam int CW = $clog2(CODE_LENGTH + 1);
	localparam int OUT_LEN = (CODE_LENGTH < OUT_CHARS) ? CODE_LENGTH : OUT_CHARS;

	logic                          at_start_q;
	logic [7:0]                    prev_code_q;
	logic [CODE_LENGTH-1:0][7:0]   buf_q;
	logic [CW-1:0]                 count_q;

	logic [7:0]                    c;
	logic [7:0]                    d;
	logic                          append;
	logic [7:0]                    append_val;
	logic [CODE_LENGTH-1:0][7:0]   buf_n;
	logic [CW-1:0]                 count_n;
	logic [OUT_CHARS-1:0][7:0]     chars;

	assign c = fold_upper(item.char_in);
	assign d = letter_code(c);
	assign has_result = item.empty_word || item.word_end;

	always_comb begin
		append = at_start_q || (d != PAD_CHAR && d != prev_code_q);
		append_val = at_start_q ? c : d;
		buf_n = buf_q;
		count_n = count_q;
		if (append && count_q < CW'(CODE_LENGTH)) begin
			count_n = count_q + CW'(1);
			for (int i = 0; i < CODE_LENGTH; i++) begin
				if (count_q == CW'(i)) begin
					buf_n[i] = append_val;
				end
			end
		end
	end

	for (genvar j = 0; j < OUT_CHARS; j++) begin : g_out
		if (j < CODE_LENGTH) begin : g_used
			assign chars[j] = item.empty_word ? 8'h00 : buf_n[j];
		end else begin : g_unused
			assign chars[j] = 8'h00;
		end
	end

	assign result.code_char0 = chars[0];
	assign result.code_char1 = chars[1];
	assign result.code_char2 = chars[2];
	assign result.code_char3 = chars[3];
	assign result.code_length = item.empty_word ? 3'd0 : 3'(OUT_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			prev_code_q <= 8'h00;
			buf_q <= {CODE_LENGTH{PAD_CHAR}};
			count_q <= '0;
		end else if (step) begin
			if (has_result) begin
				at_start_q <= 1'b1;
				prev_code_q <= 8'h00;
				buf_q <= {CODE_LENGTH{PAD_CHAR}};
				count_q <= '0;
			end else begin
				at_start_q <= 1'b0;
				prev_code_q <= d;
				buf_q <= buf_n;
				count_q <= count_n;
			end
		end
	end

endmodule

// ===== rtl/sdx_out_reg.sv =====
module sdx_out_reg import sdx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  sdx_code_t  result,
	output logic       free,
	sdx_code_if.source code_out
);

	logic      valid_q;
	sdx_code_t data_q;

	assign free = !valid_q || code_out.ready;
	assign code_out.valid = valid_q;
	assign code_out.data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (code_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

// ===== tb/sv/soundex_code_monitor.sv =====
module soundex_code_monitor import sdx_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sdx_word_if  word_ch,
	sdx_code_if  code_ch,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	bit         first_pending;
	logic [7:0] last_digit;
	logic [7:0] code_chars [8];
	int         code_fill;
	sdx_code_t  expected_codes [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'h20;
		end
		return c;
	endfunction

	function automatic logic [7:0] sound_digit(input logic [7:0] c);
		case (c)
			" ", "A", "E", "H", "I", "O", "U", "W", "Y": return PAD_CHAR;
			"B", "F", "P", "V": return DIGIT_1;
			"C", "G", "J", "K", "Q", "S", "X", "Z": return DIGIT_2;
			"D", "T": return DIGIT_3;
			"L": return DIGIT_4;
			"M", "N": return DIGIT_5;
			"R": return DIGIT_6;
			default: return c;
		endcase
	endfunction

	function void clear_word();
		first_pending = 1'b1;
		last_digit = 8'h00;
		code_fill = 0;
		foreach (code_chars[i]) begin
			code_chars[i] = PAD_CHAR;
		end
	endfunction

	function void add_code(input logic [7:0] c);
		if (code_fill < CODE_LENGTH) begin
			code_chars[code_fill] = c;
			code_fill++;
		end
	endfunction

	function void encode_char(input sdx_word_t w);
		logic [7:0] c;
		logic [7:0] d;
		sdx_code_t  code;
		code = '0;
		if (w.empty_word) begin
			expected_codes.push_back(code);
			clear_word();
			return;
		end
		c = to_upper(w.char_in);
		if (first_pending) begin
			add_code(c);
			last_digit = sound_digit(c);
			first_pending = 1'b0;
		end else begin
			d = sound_digit(c);
			if (d != PAD_CHAR && d != last_digit) begin
				add_code(d);
			end
			last_digit = d;
		end
		if (w.word_end) begin
			code.code_char0 = (CODE_LENGTH > 0) ? code_chars[0] : 8'h00;
			code.code_char1 = (CODE_LENGTH > 1) ? code_chars[1] : 8'h00;
			code.code_char2 = (CODE_LENGTH > 2) ? code_chars[2] : 8'h00;
			code.code_char3 = (CODE_LENGTH > 3) ? code_chars[3] : 8'h00;
			code.code_length = 3'((CODE_LENGTH < OUT_CHARS) ? CODE_LENGTH : OUT_CHARS);
			expected_codes.push_back(code);
			clear_word();
		end
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sdx_code_t want;
		sdx_code_t got;
		if (!arst_n) begin
			clear_word();
			expected_codes.delete();
		end else begin
			if (word_ch.valid && word_ch.ready) begin
				encode_char(word_ch.data);
			end
			if (code_ch.valid && code_ch.ready) begin
				got = code_ch.data;
				if (expected_codes.size() == 0) begin
					$error("code %h arrived with no word pending", got);
					mismatches++;
				end else begin
					want = expected_codes.pop_front();
					compare_field("code_char0", want.code_char0, got.code_char0);
					compare_field("code_char1", want.code_char1, got.code_char1);
					compare_field("code_char2", want.code_char2, got.code_char2);
					compare_field("code_char3", want.code_char3, got.code_char3);
					compare_field("code_length", 8'(want.code_length), 8'(got.code_length));
				end
			end
		end
		outstanding = expected_codes.size();
	end

endmodule

// ===== tb/sv/tb_soundex_word_encoder_core.sv =====
module tb_soundex_word_encoder_core import sdx_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off_req = 1'b0;
	int items_sent = 0;
	int code_mismatches;
	int codes_pending;

	sdx_word_if word_ch ();
	sdx_code_if code_ch ();

	soundex_word_encoder_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.word_in(word_ch),
		.code_out(code_ch)
	);

	soundex_code_monitor u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.word_ch(word_ch),
		.code_ch(code_ch),
		.mismatches(code_mismatches),
		.outstanding(codes_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("** soundex_word_encoder_core: FAILED **");
		$finish;
	end

	initial begin
		code_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				code_ch.ready <= 1'b0;
				repeat (299) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				code_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic offer_char(input logic [7:0] ch, input logic last, input logic empty);
		int gap;
		sdx_word_t w;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 64) begin
			gap++;
		end
		w.char_in = ch;
		w.word_end = last;
		w.empty_word = empty;
		@(negedge clk);
		if (gap > 0) begin
			word_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		word_ch.valid <= 1'b1;
		word_ch.data <= w;
		do begin
			@(posedge clk);
		end while (!word_ch.ready);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			offer_char(s[i], i == s.len() - 1, 1'b0);
		end
	endtask

	task automatic send_random_word();
		int r;
		int len;
		int cut;
		int pick;
		logic [7:0] ch;
		r = $urandom_range(99);
		if (r < 4) begin
			offer_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
			return;
		end
		len = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(8, 1);
		cut = (r < 9) ? $urandom_range(len - 1) : len;
		for (int i = 0; i < len; i++) begin
			if (i == cut) begin
				offer_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
				return;
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				ch = 8'h41 + 8'($urandom_range(25));
				if ($urandom_range(1)) begin
					ch = ch | 8'h20;
				end
			end else if (pick < 80) begin
				ch = 8'h20;
			end else begin
				ch = 8'($urandom_range(255));
			end
			offer_char(ch, i == len - 1, 1'b0);
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall, input int count);
		int target;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		target = items_sent + count;
		while (items_sent < target) begin
			send_random_word();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		word_ch.valid = 1'b0;
		word_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		stall_pct = 14;
		offer_char(8'h00, 1'b0, 1'b1);
		offer_char(8'hFF, 1'b1, 1'b1);
		offer_char(8'h00, 1'b1, 1'b0);
		offer_char(8'hFF, 1'b1, 1'b0);
		send_text("pfister");
		send_text("Tymczak");
		offer_char("a", 1'b0, 1'b0);
		offer_char("b", 1'b0, 1'b0);
		offer_char(8'h7E, 1'b1, 1'b1);
		offer_char("B", 1'b0, 1'b0);
		offer_char(8'h80, 1'b0, 1'b0);
		offer_char(8'h60, 1'b0, 1'b0);
		offer_char(8'h7B, 1'b1, 1'b0);

		hold_off_req = 1'b1;
		run_phase(0, 0, 475);
		run_phase(73, 0, 475);
		run_phase(0, 73, 475);
		run_phase(14, 14, 475);

		@(negedge clk);
		word_ch.valid <= 1'b0;
		stall_pct = 0;
		while (codes_pending != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (code_mismatches == 0) begin
			$display("** soundex_word_encoder_core: PASSED **");
		end else begin
			$display("** soundex_word_encoder_core: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sdx_pkg.sv
rtl/sdx_word_if.sv
rtl/sdx_code_if.sv
rtl/sdx_in_stage.sv
rtl/sdx_code_acc.sv
rtl/sdx_out_reg.sv
rtl/soundex_word_encoder_core.sv
tb/sv/soundex_code_monitor.sv
tb/sv/tb_soundex_word_encoder_core.sv
